### src/tccc_pkg.sv
// ----------------------------------------------------------------------------
// tccc_pkg
// Shared types and constants for the text console cursor controller.
// ----------------------------------------------------------------------------
package tccc_pkg;

  localparam int CELL_WIDTH_DEFAULT  = 8;
  localparam int CELL_HEIGHT_DEFAULT = 16;
  localparam int QUEUE_DEPTH         = 4;   // power of two, at least 2

  localparam int CFG_WIDTH  = 13;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int POS_WIDTH  = 12;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_WIDTH-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [CFG_WIDTH-1:0] SCREEN_HEIGHT_RESET = 13'd768;
  localparam logic [CFG_WIDTH-1:0] SCREEN_WIDTH_MIN    = 13'd8;
  localparam logic [CFG_WIDTH-1:0] SCREEN_HEIGHT_MIN   = 13'd16;
  localparam logic [CFG_WIDTH-1:0] SCREEN_MAX          = 13'd4096;

  localparam logic [7:0] CHAR_BS = 8'h08;
  localparam logic [7:0] CHAR_HT = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [7:0]            glyph_code;
    logic [POS_WIDTH-1:0]  pixel_x;
    logic [POS_WIDTH-1:0]  pixel_y;
    logic                  write_done;
    logic                  last_result;
  } result_t;

endpackage

### src/tccc_queue.sv
// ----------------------------------------------------------------------------
// tccc_queue
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module tccc_queue #(
  parameter int DEPTH = tccc_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_count,
  input  tccc_pkg::result_t         push_data [2],
  output logic                      can_take_two,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tccc_pkg::result_t         out_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tccc_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign out_data     = entries[rd_ptr];
  assign can_take_two = (count <= CW'(DEPTH - 2));
  assign level        = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(push_count) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push_data[1];
    end
  end

endmodule

### src/text_console_cursor_controller.sv
// ----------------------------------------------------------------------------
// text_console_cursor_controller
// Interprets text bytes, tracks a pixel cursor and emits draw, scroll and
// clear commands.
// ----------------------------------------------------------------------------
// One text byte is taken per clock unless the input stalls. Each byte is
// decoded against the cursor combinationally; its commands (none, one, or two
// when a drawn glyph also scrolls) go into a four-entry result queue. The
// first command is queued, and shown if the queue was empty, in the cycle
// after the byte's transfer. The output delivers one command per cycle while
// m_axis_tready is high. The input stalls only while fewer than two queue
// slots are free. The user must write screen size registers via cfg_we,
// cfg_index and cfg_data only while no byte is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module text_console_cursor_controller #(
  parameter int CELL_WIDTH  = tccc_pkg::CELL_WIDTH_DEFAULT,
  parameter int CELL_HEIGHT = tccc_pkg::CELL_HEIGHT_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tccc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tccc_pkg::CFG_WIDTH-1:0]        cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [7:0] text_byte
  input  logic                                  s_axis_tlast,  // end_of_write
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // glyph_code, pixel_x, pixel_y
  output logic [2:0]                            m_axis_tuser,  // command, write_done
  output logic                                  m_axis_tlast   // last_result
);

  localparam int PW = tccc_pkg::POS_WIDTH;
  localparam int CW = tccc_pkg::CFG_WIDTH;
  localparam int LW = $clog2(tccc_pkg::QUEUE_DEPTH + 1);

  logic [CW-1:0] screen_width;
  logic [CW-1:0] screen_height;
  logic [PW-1:0] cursor_x;
  logic [PW-1:0] cursor_y;

  logic [CW-1:0] w_eff;
  logic [CW-1:0] h_eff;
  logic [7:0]    text_byte;
  logic          accept;
  logic          has_prim;
  logic          do_scroll;
  logic          wrap;
  logic [CW-1:0] x1;
  logic [CW-1:0] y1;
  logic [CW-1:0] x2;
  logic [CW:0]   y2;
  logic [CW-1:0] y_pin;
  logic [PW-1:0] cursor_x_next;
  logic [PW-1:0] cursor_y_next;
  logic [1:0]    n_results;
  logic [1:0]    push_count;
  logic          can_take_two;
  logic [LW-1:0] q_level;

  tccc_pkg::result_t prim_res;
  tccc_pkg::result_t scroll_res;
  tccc_pkg::result_t push_data [2];
  tccc_pkg::result_t out_res;

  assign text_byte     = s_axis_tdata;
  assign s_axis_tready = can_take_two;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tccc_pkg::SCREEN_WIDTH_RESET;
      screen_height <= tccc_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tccc_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        tccc_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (screen_width < tccc_pkg::SCREEN_WIDTH_MIN) begin
      w_eff = tccc_pkg::SCREEN_WIDTH_MIN;
    end else if (screen_width > tccc_pkg::SCREEN_MAX) begin
      w_eff = tccc_pkg::SCREEN_MAX;
    end else begin
      w_eff = screen_width;
    end
    priority if (screen_height < tccc_pkg::SCREEN_HEIGHT_MIN) begin
      h_eff = tccc_pkg::SCREEN_HEIGHT_MIN;
    end else if (screen_height > tccc_pkg::SCREEN_MAX) begin
      h_eff = tccc_pkg::SCREEN_MAX;
    end else begin
      h_eff = screen_height;
    end
  end

  always_comb begin
    x1       = CW'(cursor_x);
    y1       = CW'(cursor_y);
    has_prim = 1'b1;
    unique case (text_byte)
      tccc_pkg::CHAR_LF: begin
        x1       = '0;
        y1       = CW'(cursor_y) + CW'(CELL_HEIGHT);
        has_prim = 1'b0;
      end
      tccc_pkg::CHAR_HT: begin
        x1       = CW'(cursor_x) + CW'(CELL_WIDTH);
        has_prim = 1'b0;
      end
      tccc_pkg::CHAR_BS: begin
        if (CW'(cursor_x) >= CW'(CELL_WIDTH)) begin
          x1 = CW'(cursor_x) - CW'(CELL_WIDTH);
        end
        has_prim = 1'b0;
      end
      tccc_pkg::CHAR_CR: begin
        x1       = '0;
        has_prim = 1'b0;
      end
      tccc_pkg::CHAR_FF: begin
        x1 = '0;
        y1 = '0;
      end
      default: begin
        x1 = CW'(cursor_x) + CW'(CELL_WIDTH);
      end
    endcase
  end

  always_comb begin
    wrap      = ((CW+1)'(x1) + (CW+1)'(CELL_WIDTH)) > (CW+1)'(w_eff);
    x2        = wrap ? '0 : x1;
    y2        = wrap ? ((CW+1)'(y1) + (CW+1)'(CELL_HEIGHT)) : (CW+1)'(y1);
    do_scroll = (y2 + (CW+1)'(CELL_HEIGHT)) > (CW+1)'(h_eff);
    y_pin     = (h_eff >= CW'(CELL_HEIGHT)) ? (h_eff - CW'(CELL_HEIGHT)) : '0;
    cursor_x_next = x2[PW-1:0];
    cursor_y_next = do_scroll ? y_pin[PW-1:0] : y2[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

  always_comb begin
    n_results = 2'(has_prim) + 2'(do_scroll);
    push_count = accept ? n_results : 2'd0;

    prim_res = '0;
    if (text_byte == tccc_pkg::CHAR_FF) begin
      prim_res.command = tccc_pkg::CMD_CLEAR;
    end else begin
      prim_res.command    = tccc_pkg::CMD_DRAW;
      prim_res.glyph_code = text_byte;
      prim_res.pixel_x    = cursor_x;
      prim_res.pixel_y    = cursor_y;
    end
    prim_res.last_result = !do_scroll;
    prim_res.write_done  = !do_scroll && s_axis_tlast;

    scroll_res             = '0;
    scroll_res.command     = tccc_pkg::CMD_SCROLL;
    scroll_res.last_result = 1'b1;
    scroll_res.write_done  = s_axis_tlast;

    push_data[0] = has_prim ? prim_res : scroll_res;
    push_data[1] = scroll_res;
  end

  tccc_queue #(
    .DEPTH(tccc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_data   (push_data),
    .can_take_two(can_take_two),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (out_res),
    .level       (q_level)
  );

  assign m_axis_tdata = {out_res.pixel_y, out_res.pixel_x, out_res.glyph_code};
  assign m_axis_tuser = {out_res.write_done, out_res.command};
  assign m_axis_tlast = out_res.last_result;

  a_first_of_pair_has_partner: assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> q_level >= LW'(2)
  ) else $error("first result of a pair has no partner queued");

  a_write_done_on_last: assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast
  ) else $error("write_done flagged on a result that is not the last");

  a_form_feed_homes_x: assert property (
    @(posedge clk) disable iff (rst)
    accept && text_byte == tccc_pkg::CHAR_FF |=> cursor_x == '0
  ) else $error("form feed left the cursor off column zero");

endmodule

### bench/text_console_cursor_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_controller_tb
// Feeds text bytes through the stream input under a series of screen sizes,
// including out-of-range register values that must saturate. A cursor
// tracker in the bench predicts every draw, scroll and clear command.
// Each output transfer is compared field by field against the oldest
// prediction. Both sides idle at random, and the output is held off for a
// long stretch once so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module text_console_cursor_controller_tb;

  localparam int CELL_W         = tccc_pkg::CELL_WIDTH_DEFAULT;
  localparam int CELL_H         = tccc_pkg::CELL_HEIGHT_DEFAULT;
  localparam int NUM_SCREENS    = 9;
  localparam int RANDOM_PER_SCR = 136;
  localparam int LONG_HOLD      = 200;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct {
    logic [7:0] text;
    logic       eow;
  } text_item_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [tccc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = tccc_pkg::REG_SCREEN_WIDTH;
  logic [tccc_pkg::CFG_WIDTH-1:0]       cfg_data = '0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [7:0]                           s_axis_tdata = '0;  // [7:0] text_byte
  logic                                 s_axis_tlast = 1'b0;  // end_of_write
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  // [7:0] glyph_code, [19:8] pixel_x, [31:20] pixel_y
  logic [31:0]                          m_axis_tdata;
  logic [2:0]                           m_axis_tuser;  // [1:0] command, [2] write_done
  logic                                 m_axis_tlast;  // last_result

  text_item_t                     text_backlog[$];
  tccc_pkg::result_t              pending_cmds[$];
  logic [tccc_pkg::CFG_WIDTH-1:0] scr_width  = tccc_pkg::SCREEN_WIDTH_RESET;
  logic [tccc_pkg::CFG_WIDTH-1:0] scr_height = tccc_pkg::SCREEN_HEIGHT_RESET;
  int   cur_x = 0;
  int   cur_y = 0;
  bit   idle_on = 1'b1;
  bit   long_hold_req = 1'b0;
  int   send_gap = 0;
  int   hold_left = 0;
  int   fails = 0;
  int   n_bytes = 0;
  int   n_draw = 0;
  int   n_scroll = 0;
  int   n_clear = 0;

  text_console_cursor_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one byte to the tracked cursor and queue the commands it causes.
  task automatic advance_cursor(input logic [7:0] text, input logic eow);
    int                w;
    int                h;
    int                x;
    int                y;
    bit                has_first;
    bit                scrolled;
    tccc_pkg::result_t first;
    w = int'(scr_width);
    h = int'(scr_height);
    if (w < int'(tccc_pkg::SCREEN_WIDTH_MIN)) w = int'(tccc_pkg::SCREEN_WIDTH_MIN);
    if (w > int'(tccc_pkg::SCREEN_MAX)) w = int'(tccc_pkg::SCREEN_MAX);
    if (h < int'(tccc_pkg::SCREEN_HEIGHT_MIN)) h = int'(tccc_pkg::SCREEN_HEIGHT_MIN);
    if (h > int'(tccc_pkg::SCREEN_MAX)) h = int'(tccc_pkg::SCREEN_MAX);
    x = cur_x;
    y = cur_y;
    has_first = 1'b0;
    scrolled = 1'b0;
    first = '{tccc_pkg::CMD_DRAW, 8'd0, 12'd0, 12'd0, 1'b0, 1'b0};
    case (text)
      tccc_pkg::CHAR_LF: begin
        x = 0;
        y = y + CELL_H;
      end
      tccc_pkg::CHAR_HT: x = x + CELL_W;
      tccc_pkg::CHAR_BS: begin
        if (x >= CELL_W) x = x - CELL_W;
      end
      tccc_pkg::CHAR_CR: x = 0;
      tccc_pkg::CHAR_FF: begin
        has_first = 1'b1;
        first.command = tccc_pkg::CMD_CLEAR;
        x = 0;
        y = 0;
      end
      default: begin
        has_first = 1'b1;
        first.command = tccc_pkg::CMD_DRAW;
        first.glyph_code = text;
        first.pixel_x = tccc_pkg::POS_WIDTH'(x);
        first.pixel_y = tccc_pkg::POS_WIDTH'(y);
        x = x + CELL_W;
      end
    endcase
    if (x + CELL_W > w) begin
      x = 0;
      y = y + CELL_H;
    end
    if (y + CELL_H > h) begin
      scrolled = 1'b1;
      y = (h >= CELL_H) ? h - CELL_H : 0;
    end
    cur_x = x & 12'hFFF;
    cur_y = y & 12'hFFF;
    if (has_first) begin
      first.write_done = scrolled ? 1'b0 : eow;
      first.last_result = !scrolled;
      pending_cmds.push_back(first);
    end
    if (scrolled)
      pending_cmds.push_back('{tccc_pkg::CMD_SCROLL, 8'd0, 12'd0, 12'd0, eow, 1'b1});
  endtask

  function automatic logic [7:0] pick_text_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (sel < 80) begin
      case ($urandom_range(0, 4))
        0: return tccc_pkg::CHAR_BS;
        1: return tccc_pkg::CHAR_HT;
        2: return tccc_pkg::CHAR_LF;
        3: return tccc_pkg::CHAR_CR;
        default: return tccc_pkg::CHAR_FF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_text(input logic [7:0] text, input logic eow);
    text_backlog.push_back('{text, eow});
  endtask

  task automatic wait_drained();
    while (text_backlog.size() != 0 || s_axis_tvalid || pending_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen_reg(input logic [tccc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= tccc_pkg::CFG_WIDTH'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tccc_pkg::REG_SCREEN_WIDTH) scr_width = tccc_pkg::CFG_WIDTH'(value);
    else scr_height = tccc_pkg::CFG_WIDTH'(value);
  endtask

  // Sender: hold each byte until its transfer, idle in random bursts.
  always @(posedge clk) begin : drive_text
    text_item_t item;
    logic       offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_cursor(s_axis_tdata, s_axis_tlast);
        n_bytes++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (text_backlog.size() != 0) begin
          if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 15);
          end else begin
            item = text_backlog.pop_front();
            offer = 1'b1;
            s_axis_tdata <= item.text;
            s_axis_tlast <= item.eow;
          end
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // Receiver: compare each command transfer, stall in random bursts.
  always @(posedge clk) begin : check_cmds
    tccc_pkg::result_t want;
    tccc_pkg::result_t got;
    logic              rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.command     = tccc_pkg::cmd_t'(m_axis_tuser[1:0]);
        got.write_done  = m_axis_tuser[2];
        got.glyph_code  = m_axis_tdata[7:0];
        got.pixel_x     = m_axis_tdata[19:8];
        got.pixel_y     = m_axis_tdata[31:20];
        got.last_result = m_axis_tlast;
        if (pending_cmds.size() == 0) begin
          $error("unexpected command transfer: tuser %h tdata %h tlast %b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
          fails++;
        end else begin
          want = pending_cmds.pop_front();
          if (got.command !== want.command) begin
            $error("command: expected %0d, got %0d", want.command, got.command);
            fails++;
          end
          if (got.glyph_code !== want.glyph_code) begin
            $error("glyph_code: expected %h, got %h", want.glyph_code, got.glyph_code);
            fails++;
          end
          if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            fails++;
          end
          if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            fails++;
          end
          if (got.write_done !== want.write_done) begin
            $error("write_done: expected %b, got %b", want.write_done, got.write_done);
            fails++;
          end
          if (got.last_result !== want.last_result) begin
            $error("last_result: expected %b, got %b", want.last_result, got.last_result);
            fails++;
          end
          case (want.command)
            tccc_pkg::CMD_DRAW:   n_draw++;
            tccc_pkg::CMD_SCROLL: n_scroll++;
            default:              n_clear++;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 15);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  initial begin : run_screens
    int widths[NUM_SCREENS];
    int heights[NUM_SCREENS];
    widths  = '{1024, 0, 8191, 4096, 8, 13, 40, 100, 640};
    heights = '{768, 0, 8191, 4096, 16, 40, 48, 200, 480};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < NUM_SCREENS; s++) begin
      if (s > 0) begin
        write_screen_reg(tccc_pkg::REG_SCREEN_WIDTH, widths[s]);
        write_screen_reg(tccc_pkg::REG_SCREEN_HEIGHT, heights[s]);
      end
      if (s == NUM_SCREENS - 1) idle_on = 1'b0;
      @(negedge clk);
      if (s == 0) begin
        queue_text("A", 1'b0);
        queue_text(8'h00, 1'b1);
        queue_text(8'hFF, 1'b0);
        queue_text(tccc_pkg::CHAR_BS, 1'b0);
        queue_text(tccc_pkg::CHAR_BS, 1'b0);
        queue_text(tccc_pkg::CHAR_BS, 1'b0);
        queue_text(tccc_pkg::CHAR_BS, 1'b1);
        queue_text(tccc_pkg::CHAR_HT, 1'b0);
        queue_text(8'h7F, 1'b1);
        queue_text(tccc_pkg::CHAR_CR, 1'b1);
        queue_text(tccc_pkg::CHAR_LF, 1'b0);
        queue_text("z", 1'b1);
        queue_text(tccc_pkg::CHAR_FF, 1'b1);
        queue_text(tccc_pkg::CHAR_FF, 1'b0);
        queue_text(8'h80, 1'b1);
        wait_drained();
        @(negedge clk);
      end else if (s == 1) begin
        queue_text("B", 1'b1);
        queue_text(tccc_pkg::CHAR_LF, 1'b1);
        queue_text(tccc_pkg::CHAR_HT, 1'b0);
        queue_text(tccc_pkg::CHAR_FF, 1'b1);
        queue_text(tccc_pkg::CHAR_BS, 1'b0);
      end else if (s == 2) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < RANDOM_PER_SCR; i++)
        queue_text(pick_text_byte(), $urandom_range(0, 3) == 0);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    $display("Covered %0d bytes over %0d screen sizes, saturated sizes included.",
             n_bytes, NUM_SCREENS);
    $display("Checked %0d draw, %0d scroll and %0d clear commands.",
             n_draw, n_scroll, n_clear);
    if (fails == 0) begin
      $display("text_console_cursor_controller_tb passed");
    end else begin
      $display("text_console_cursor_controller_tb failed");
    end
    $finish;
  end

  initial begin : run_limit
    #5_000_000;
    $display("text_console_cursor_controller_tb failed");
    $finish;
  end

endmodule
